@@ sv/tpc_pkg.sv @@
package tpc_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int T_BITS    = 61 - COORD_W;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = COORD_W + DIFF_W;
  localparam int DIST_W    = PROD_W + 2;
  localparam int DEN_W     = DIST_W + 1;
  localparam int NORM_W    = COORD_W + 2;
  localparam int REM_W     = NORM_W + 1;
  localparam int Q_W       = T_BITS + 1;
  localparam int MUL_W     = DIFF_W + Q_W + 1;
  localparam int DIV_BITS  = 2;
  localparam int DIV_ST    = (Q_W + DIV_BITS - 1) / DIV_BITS;
  localparam int ISECT_LAT = DIV_ST + 5;
  localparam int IDX_W     = 3;
  localparam int ATTR_W    = 16;

  typedef logic [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vec_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [1:0] kind_t;

  localparam logic [IDX_W-1:0] REG_PX = 3'd0;
  localparam logic [IDX_W-1:0] REG_PY = 3'd1;
  localparam logic [IDX_W-1:0] REG_PZ = 3'd2;
  localparam logic [IDX_W-1:0] REG_NX = 3'd3;
  localparam logic [IDX_W-1:0] REG_NY = 3'd4;
  localparam logic [IDX_W-1:0] REG_NZ = 3'd5;

  localparam kind_t KIND_PASS = 2'd0;
  localparam kind_t KIND_ONE  = 2'd1;
  localparam kind_t KIND_TWO  = 2'd2;

  localparam coord_t PZ_RST = COORD_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam coord_t NZ_RST = COORD_W'(64'd1 << FRAC_BITS);

  typedef struct packed {
    kind_t               kind;
    vec_t                s0;
    vec_t                s1;
    vec_t                s2;
    logic [ATTR_W-1:0]   colour;
    logic [ATTR_W-1:0]   symbol;
  } side_t;

endpackage

@@ sv/tpc_isect.sv @@
module tpc_isect import tpc_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  vec_t  a,
  input  vec_t  b,
  input  dist_t da,
  input  dist_t db,
  output vec_t  r
);

  localparam int LINE = DIV_ST + 3;
  localparam logic signed [MUL_W-1:0] RND = MUL_W'(1) << (T_BITS - 1);

  logic [DEN_W-1:0]  num0, den0, num1, den1;
  logic [DEN_W-1:0]  num1_next, den1_next, num2_full, den2_full;
  logic [NORM_W-1:0] num2, den2;
  logic [REM_W-1:0]  rem_s [DIV_ST];
  logic [REM_W-1:0]  rem_next [DIV_ST];
  logic [NORM_W-1:0] dd_s [DIV_ST];
  logic [Q_W-1:0]    q_s [DIV_ST];
  logic [Q_W-1:0]    q_next [DIV_ST];
  vec_t              a_d [LINE];
  logic [DIFF_W-1:0] diff_d [LINE][3];
  vec_t              a_m;
  logic signed [MUL_W-1:0] prod [3];
  logic signed [MUL_W-1:0] rsum [3];
  logic signed [MUL_W-1:0] rsh [3];

  // normalize the denominator below 2^NORM_W, coarse then fine
  always_comb begin
    int sh;
    num1_next = num0;
    den1_next = den0;
    for (int k = 0; k < 3; k++) begin
      sh = 32 >> k;
      if ((den1_next >> (NORM_W - 1 + sh)) != '0) begin
        num1_next = num1_next >> sh;
        den1_next = den1_next >> sh;
      end
    end
    num2_full = num1;
    den2_full = den1;
    for (int k = 3; k < 6; k++) begin
      sh = 32 >> k;
      if ((den2_full >> (NORM_W - 1 + sh)) != '0) begin
        num2_full = num2_full >> sh;
        den2_full = den2_full >> sh;
      end
    end
  end

  // restoring divider, DIV_BITS quotient bits per stage
  always_comb begin
    logic [REM_W-1:0]  rm;
    logic [NORM_W-1:0] dv;
    logic [Q_W-1:0]    qq;
    int idx;
    for (int k = 0; k < DIV_ST; k++) begin
      if (k == 0) begin
        rm = {1'b0, num2};
        dv = den2;
        qq = '0;
      end else begin
        rm = rem_s[k-1];
        dv = dd_s[k-1];
        qq = q_s[k-1];
      end
      for (int j = 0; j < DIV_BITS; j++) begin
        idx = k * DIV_BITS + j;
        if (idx < Q_W) begin
          if (idx != 0) rm = rm << 1;
          if (rm >= {1'b0, dv}) begin
            rm = rm - {1'b0, dv};
            qq = {qq[Q_W-2:0], 1'b1};
          end else begin
            qq = {qq[Q_W-2:0], 1'b0};
          end
        end
      end
      rem_next[k] = rm;
      q_next[k]   = qq;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = prod[i] + RND;
      rsh[i]  = rsum[i] >>> T_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0 <= {1'b0, da};
      den0 <= {da[DIST_W-1], da} - {db[DIST_W-1], db};
      num1 <= num1_next;
      den1 <= den1_next;
      num2 <= num2_full[NORM_W-1:0];
      den2 <= den2_full[NORM_W-1:0];
      for (int k = 0; k < DIV_ST; k++) begin
        rem_s[k] <= rem_next[k];
        q_s[k]   <= q_next[k];
        dd_s[k]  <= (k == 0) ? den2 : dd_s[k-1];
      end
      a_d[0] <= a;
      for (int i = 0; i < 3; i++) begin
        diff_d[0][i] <= {b[i][COORD_W-1], b[i]} - {a[i][COORD_W-1], a[i]};
      end
      for (int k = 1; k < LINE; k++) begin
        a_d[k] <= a_d[k-1];
        for (int i = 0; i < 3; i++) diff_d[k][i] <= diff_d[k-1][i];
      end
      a_m <= a_d[LINE-1];
      for (int i = 0; i < 3; i++) begin
        prod[i] <= $signed(diff_d[LINE-1][i]) * $signed({1'b0, q_s[DIV_ST-1]});
        r[i]    <= a_m[i] + rsh[i][COORD_W-1:0];
      end
    end
  end

endmodule

@@ sv/triangle_plane_clip.sv @@
// Clips one triangle per item against the plane set by the six registers, in signed
// Q16.16. An item is taken whenever start is high and busy is low, one per cycle; a
// triangle cut into two gives its two results on consecutive cycles, and busy is high
// for the one cycle in which the pipeline stalls to let the second go out. Each result
// passes the distance pipeline, the split stage and the pipelined restoring divider for
// the cut parameter, and waits out the stall of every split triangle ahead of it.
// The valid strobe marks each result for exactly one cycle and the receiver cannot stall.
// Triangles fully outside give no result; last_of_run marks the final result of a triangle.
module triangle_plane_clip import tpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [COORD_W-1:0] wr_data,
  input  logic [COORD_W-1:0] v0_x,
  input  logic [COORD_W-1:0] v0_y,
  input  logic [COORD_W-1:0] v0_z,
  input  logic [COORD_W-1:0] v1_x,
  input  logic [COORD_W-1:0] v1_y,
  input  logic [COORD_W-1:0] v1_z,
  input  logic [COORD_W-1:0] v2_x,
  input  logic [COORD_W-1:0] v2_y,
  input  logic [COORD_W-1:0] v2_z,
  input  logic [ATTR_W-1:0] shade_colour,
  input  logic [ATTR_W-1:0] shade_symbol,
  output logic              valid,
  output logic [COORD_W-1:0] o0_x,
  output logic [COORD_W-1:0] o0_y,
  output logic [COORD_W-1:0] o0_z,
  output logic [COORD_W-1:0] o1_x,
  output logic [COORD_W-1:0] o1_y,
  output logic [COORD_W-1:0] o1_z,
  output logic [COORD_W-1:0] o2_x,
  output logic [COORD_W-1:0] o2_y,
  output logic [COORD_W-1:0] o2_z,
  output logic [ATTR_W-1:0] out_colour,
  output logic [ATTR_W-1:0] out_symbol,
  output logic              last_of_run
);

  coord_t pp [3];
  coord_t pn [3];
  logic   hold;
  logic   en;

  logic   val0, val1, val2, val3, val4;
  vec_t   st0 [3];
  vec_t   st1 [3];
  vec_t   st2 [3];
  vec_t   st3 [3];
  logic [ATTR_W-1:0] col0, col1, col2, col3, sym0, sym1, sym2, sym3;
  logic [DIFF_W-1:0] e1 [3][3];
  logic signed [PROD_W-1:0] p2 [3][3];
  dist_t  d3 [3];

  side_t  t4;
  side_t  t4_next;
  logic   t4_val_next;
  vec_t   ia, ib, ic, id;
  dist_t  da1, db1, da2, db2;
  logic [1:0] ka, kb, kc;
  logic [2:0] mask;

  side_t  sd [ISECT_LAT];
  logic [ISECT_LAT-1:0] sdv;
  side_t  tail;
  vec_t   r1, r2;
  vec_t   ov0, ov1, ov2;

  // stall while the first of two results goes out, so the tail stays for the second
  assign busy = sdv[ISECT_LAT-1] && (tail.kind == KIND_TWO) && !hold;
  assign en   = !busy;
  assign tail = sd[ISECT_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pp[0] <= '0;
      pp[1] <= '0;
      pp[2] <= PZ_RST;
      pn[0] <= '0;
      pn[1] <= '0;
      pn[2] <= NZ_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_PX: pp[0] <= wr_data;
        REG_PY: pp[1] <= wr_data;
        REG_PZ: pp[2] <= wr_data;
        REG_NX: pn[0] <= wr_data;
        REG_NY: pn[1] <= wr_data;
        REG_NZ: pn[2] <= wr_data;
        default: ;
      endcase
    end
  end

  // control valids
  always_ff @(posedge clk) begin
    if (rst) begin
      val0 <= 1'b0;
      val1 <= 1'b0;
      val2 <= 1'b0;
      val3 <= 1'b0;
      val4 <= 1'b0;
      sdv  <= '0;
    end else if (en) begin
      val0 <= start;
      val1 <= val0;
      val2 <= val1;
      val3 <= val2;
      val4 <= t4_val_next;
      sdv  <= {sdv[ISECT_LAT-2:0], val4};
    end
  end

  // distance pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      st0[0] <= {v0_z, v0_y, v0_x};
      st0[1] <= {v1_z, v1_y, v1_x};
      st0[2] <= {v2_z, v2_y, v2_x};
      col0 <= shade_colour;
      sym0 <= shade_symbol;
      st1 <= st0;
      st2 <= st1;
      st3 <= st2;
      col1 <= col0;
      col2 <= col1;
      col3 <= col2;
      sym1 <= sym0;
      sym2 <= sym1;
      sym3 <= sym2;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          e1[k][i] <= {st0[k][i][COORD_W-1], st0[k][i]} - {pp[i][COORD_W-1], pp[i]};
          p2[k][i] <= $signed(pn[i]) * $signed(e1[k][i]);
        end
        d3[k] <= {{2{p2[k][0][PROD_W-1]}}, p2[k][0]}
               + {{2{p2[k][1][PROD_W-1]}}, p2[k][1]}
               + {{2{p2[k][2][PROD_W-1]}}, p2[k][2]};
      end
    end
  end

  // split into inside and outside vertices
  always_comb begin
    for (int k = 0; k < 3; k++) mask[k] = !d3[k][DIST_W-1];
    ka = 2'd0;
    kb = 2'd1;
    kc = 2'd2;
    t4_next.kind = KIND_PASS;
    case (mask)
      3'b001: begin ka = 2'd0; kb = 2'd1; kc = 2'd2; t4_next.kind = KIND_ONE; end
      3'b010: begin ka = 2'd1; kb = 2'd0; kc = 2'd2; t4_next.kind = KIND_ONE; end
      3'b100: begin ka = 2'd2; kb = 2'd0; kc = 2'd1; t4_next.kind = KIND_ONE; end
      3'b011: begin ka = 2'd0; kb = 2'd1; kc = 2'd2; t4_next.kind = KIND_TWO; end
      3'b101: begin ka = 2'd0; kb = 2'd2; kc = 2'd1; t4_next.kind = KIND_TWO; end
      3'b110: begin ka = 2'd1; kb = 2'd2; kc = 2'd0; t4_next.kind = KIND_TWO; end
      default: ;
    endcase
    t4_val_next    = val3 && (mask != 3'b000);
    t4_next.s0     = st3[ka];
    t4_next.s1     = st3[kb];
    t4_next.s2     = st3[kc];
    t4_next.colour = col3;
    t4_next.symbol = sym3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4 <= t4_next;
      ia <= st3[ka];
      da1 <= d3[ka];
      if (t4_next.kind == KIND_ONE) begin
        ib  <= st3[kb];
        db1 <= d3[kb];
        ic  <= st3[ka];
        da2 <= d3[ka];
      end else begin
        ib  <= st3[kc];
        db1 <= d3[kc];
        ic  <= st3[kb];
        da2 <= d3[kb];
      end
      id  <= st3[kc];
      db2 <= d3[kc];
      sd[0] <= t4;
      for (int k = 1; k < ISECT_LAT; k++) sd[k] <= sd[k-1];
    end
  end

  tpc_isect u_isect1 (
    .clk (clk), .en (en), .a (ia), .b (ib), .da (da1), .db (db1), .r (r1)
  );

  tpc_isect u_isect2 (
    .clk (clk), .en (en), .a (ic), .b (id), .da (da2), .db (db2), .r (r2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      hold        <= 1'b0;
      last_of_run <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (hold) begin
        valid       <= 1'b1;
        hold        <= 1'b0;
        last_of_run <= 1'b1;
      end else if (sdv[ISECT_LAT-1]) begin
        valid       <= 1'b1;
        hold        <= (tail.kind == KIND_TWO);
        last_of_run <= (tail.kind != KIND_TWO);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_colour <= tail.colour;
    out_symbol <= tail.symbol;
    if (hold) begin
      ov0 <= tail.s1;
      ov1 <= r1;
      ov2 <= r2;
    end else begin
      case (tail.kind)
        KIND_ONE: begin ov0 <= tail.s0; ov1 <= r1;      ov2 <= r2; end
        KIND_TWO: begin ov0 <= tail.s0; ov1 <= tail.s1; ov2 <= r1; end
        default:  begin ov0 <= tail.s0; ov1 <= tail.s1; ov2 <= tail.s2; end
      endcase
    end
  end

  assign o0_x = ov0[0];
  assign o0_y = ov0[1];
  assign o0_z = ov0[2];
  assign o1_x = ov1[0];
  assign o1_y = ov1[1];
  assign o1_z = ov1[2];
  assign o2_x = ov2[0];
  assign o2_y = ov2[1];
  assign o2_z = ov2[2];

  a_hold_single: assert property (@(posedge clk) disable iff (rst)
    hold |=> !hold)
    else $error("second result held for more than one cycle");

  a_two_holds: assert property (@(posedge clk) disable iff (rst)
    (sdv[ISECT_LAT-1] && tail.kind == KIND_TWO && !hold) |=> (hold && valid && !last_of_run))
    else $error("split triangle did not hold for its second result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (valid && !$past(hold)) |-> $past(sdv[ISECT_LAT-1]))
    else $error("result strobe without an item at the pipeline end");

  a_second_last: assert property (@(posedge clk) disable iff (rst)
    $past(hold) |-> (valid && last_of_run))
    else $error("second result missing or not marked last");

endmodule
